/* hdl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg - shared types and constants of the subnet list match block
//
// Field codes, stream widths and the layouts of the two table memories.
// ----------------------------------------------------------------------------
package slm_pkg;

  // Request kinds carried in the slave-side tuser
  localparam logic [1:0] MODE_WR_V4  = 2'd0;
  localparam logic [1:0] MODE_WR_V6  = 2'd1;
  localparam logic [1:0] MODE_QRY_V4 = 2'd2;
  localparam logic [1:0] MODE_QRY_V6 = 2'd3;

  // Configuration register indexes
  localparam logic REG_V4_COUNT = 1'b0;
  localparam logic REG_V6_COUNT = 1'b1;

  // Port widths
  localparam int S_TDATA_W   = 264;
  localparam int S_TUSER_W   = 2;
  localparam int M_TDATA_W   = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int COUNT_W     = 7;
  localparam int INDEX_W     = 6;

  // One IPv4 table word
  typedef struct packed {
    logic [31:0] mask;
    logic [31:0] network;
  } v4_entry_t;

  // One IPv6 table word
  typedef struct packed {
    logic [63:0] mask_lo;
    logic [63:0] mask_hi;
    logic [63:0] network_lo;
    logic [63:0] network_hi;
  } v6_entry_t;

  // Query request handed to the scan engine
  typedef struct packed {
    logic        is_query;
    logic        is_v6;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } query_t;

endpackage

/* hdl/subnet_list_match.sv */
// ----------------------------------------------------------------------------
// subnet_list_match - IPv4/IPv6 subnet list membership test
//
// Two tables of network/mask pairs; write requests load entries, query
// requests return whether an address lies in a listed network.
// ----------------------------------------------------------------------------
// A write request (tuser mode 0 or 1) loads one entry of the IPv4 or IPv6
// table in the cycle it is accepted and gives no result; entry indexes at or
// beyond TABLE_ENTRIES are dropped. A query request (mode 2 or 3) gives one
// result, listed in m_tdata bit 0. A query scans entries 0 up to
// min(count, TABLE_ENTRIES) - 1 of its table, one read of the table memory
// per cycle, and stops at the first match or at an entry whose network and
// mask are all zero; the input stays closed until its answer has entered the
// output register. While an earlier result still waits in the output
// register, a finished query holds its answer and the input stays closed
// until that register frees. The tables are not cleared after reset: a query
// must only reach entries that were written. Set the entry counts through
// the configuration port while no query is in flight.
module subnet_list_match #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [5:0] entry_index, [69:6] addr_hi, [133:70] addr_lo,
  // [197:134] mask_hi, [261:198] mask_lo, [263:262] zero
  input  logic [slm_pkg::S_TDATA_W-1:0]     s_tdata,
  // [1:0] mode
  input  logic [slm_pkg::S_TUSER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] listed, [7:1] zero
  output logic [slm_pkg::M_TDATA_W-1:0]     m_tdata,
  input  logic                              cfg_we,
  input  logic [slm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [slm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import slm_pkg::*;

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [1:0]         mode;
  logic [INDEX_W-1:0] entry_index;
  logic [63:0]        addr_hi, addr_lo, mask_hi, mask_lo;
  logic [COUNT_W-1:0] v4_count, v6_count, sel_count;
  logic [CW-1:0]      query_limit;
  logic               accept, idx_ok, v4_we, v6_we;
  logic [AW-1:0]      waddr;
  v4_entry_t          v4_wdata, v4_rdata;
  v6_entry_t          v6_wdata, v6_rdata;
  query_t             query;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               m_listed;

  // Unpack the request
  assign mode        = s_tuser[1:0];
  assign entry_index = s_tdata[5:0];
  assign addr_hi     = s_tdata[69:6];
  assign addr_lo     = s_tdata[133:70];
  assign mask_hi     = s_tdata[197:134];
  assign mask_lo     = s_tdata[261:198];

  // Entry count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      v4_count <= '0;
      v6_count <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_V4_COUNT: v4_count <= cfg_data;
        REG_V6_COUNT: v6_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Saturate the scan length at the table size
  always_comb begin
    sel_count = (mode == MODE_QRY_V6) ? v6_count : v4_count;
    if (32'(sel_count) > TABLE_ENTRIES) begin
      query_limit = CW'(TABLE_ENTRIES);
    end else begin
      query_limit = CW'(sel_count);
    end
  end

  // Table writes
  assign accept   = s_tvalid && s_tready;
  assign idx_ok   = 32'(entry_index) < TABLE_ENTRIES;
  assign v4_we    = accept && (mode == MODE_WR_V4) && idx_ok;
  assign v6_we    = accept && (mode == MODE_WR_V6) && idx_ok;
  assign waddr    = AW'(entry_index);
  assign v4_wdata = '{mask: mask_lo[31:0], network: addr_lo[31:0]};
  assign v6_wdata = '{mask_lo: mask_lo, mask_hi: mask_hi,
                      network_lo: addr_lo, network_hi: addr_hi};

  // Query request
  assign query.is_query = (mode == MODE_QRY_V4) || (mode == MODE_QRY_V6);
  assign query.is_v6    = (mode == MODE_QRY_V6);
  assign query.addr_hi  = addr_hi;
  assign query.addr_lo  = addr_lo;

  slm_ram #(
    .WIDTH  ($bits(v4_entry_t)),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (AW)
  ) u_v4_table (
    .clk   (clk),
    .we    (v4_we),
    .waddr (waddr),
    .wdata (v4_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (v4_rdata)
  );

  slm_ram #(
    .WIDTH  ($bits(v6_entry_t)),
    .DEPTH  (TABLE_ENTRIES),
    .ADDR_W (AW)
  ) u_v6_table (
    .clk   (clk),
    .we    (v6_we),
    .waddr (waddr),
    .wdata (v6_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (v6_rdata)
  );

  slm_scan #(
    .ADDR_W  (AW),
    .LIMIT_W (CW)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .s_valid     (s_tvalid),
    .s_ready     (s_tready),
    .query       (query),
    .query_limit (query_limit),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .v4_rdata    (v4_rdata),
    .v6_rdata    (v6_rdata),
    .m_valid     (m_tvalid),
    .m_ready     (m_tready),
    .m_listed    (m_listed)
  );

  assign m_tdata = {{(M_TDATA_W-1){1'b0}}, m_listed};

endmodule

/* hdl/slm_ram.sv */
// ----------------------------------------------------------------------------
// slm_ram - simple dual-port table memory
//
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slm_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one word, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/slm_scan.sv */
// ----------------------------------------------------------------------------
// slm_scan - query scan engine
//
// Walks the selected table one entry per cycle, compares the masked address
// with each masked network, stops at a match, a terminator entry or the scan
// limit and holds the answer in the output register.
// ----------------------------------------------------------------------------
module slm_scan #(
  parameter int ADDR_W  = 6,
  parameter int LIMIT_W = 7
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_valid,
  output logic                   s_ready,
  input  slm_pkg::query_t        query,
  input  logic [LIMIT_W-1:0]     query_limit,
  output logic                   rd_en,
  output logic [ADDR_W-1:0]      rd_addr,
  input  slm_pkg::v4_entry_t     v4_rdata,
  input  slm_pkg::v6_entry_t     v6_rdata,
  output logic                   m_valid,
  input  logic                   m_ready,
  output logic                   m_listed
);
  import slm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t             state, state_next;
  logic [LIMIT_W-1:0] k, k_next;
  logic [LIMIT_W-1:0] limit;
  logic               pend;
  logic               is_v6;
  logic [63:0]        a_hi, a_lo;
  logic               listed, listed_next;

  logic v4_term, v4_hit, v6_term, v6_hit, term, hit, at_end, out_free, start;

  // Compare the word read last cycle
  always_comb begin
    v4_term = (v4_rdata.network == 32'd0) && (v4_rdata.mask == 32'd0);
    v4_hit  = (a_lo[31:0] & v4_rdata.mask) == (v4_rdata.network & v4_rdata.mask);
    v6_term = (v6_rdata.network_hi == 64'd0) && (v6_rdata.network_lo == 64'd0) &&
              (v6_rdata.mask_hi == 64'd0) && (v6_rdata.mask_lo == 64'd0);
    v6_hit  = ((a_hi & v6_rdata.mask_hi) == (v6_rdata.network_hi & v6_rdata.mask_hi)) &&
              ((a_lo & v6_rdata.mask_lo) == (v6_rdata.network_lo & v6_rdata.mask_lo));
    term    = is_v6 ? v6_term : v4_term;
    hit     = is_v6 ? v6_hit : v4_hit;
  end

  assign s_ready  = (state == ST_IDLE);
  assign start    = s_valid && s_ready && query.is_query;
  assign at_end   = (k == limit);
  assign out_free = !m_valid || m_ready;
  assign rd_addr  = k[ADDR_W-1:0];

  // Sequence the scan
  always_comb begin
    state_next  = state;
    k_next      = k;
    listed_next = listed;
    rd_en       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
          k_next     = '0;
        end
      end
      ST_SCAN: begin
        if (pend && term) begin
          listed_next = 1'b0;
          state_next  = ST_HOLD;
        end else if (pend && hit) begin
          listed_next = 1'b1;
          state_next  = ST_HOLD;
        end else if (at_end) begin
          listed_next = 1'b0;
          state_next  = ST_HOLD;
        end else begin
          rd_en  = 1'b1;
          k_next = k + 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pend    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= rd_en;
      if (state == ST_HOLD && out_free) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    k      <= k_next;
    listed <= listed_next;
    if (start) begin
      limit <= query_limit;
      is_v6 <= query.is_v6;
      a_hi  <= query.addr_hi;
      a_lo  <= query.addr_lo;
    end
    if (state == ST_HOLD && out_free) begin
      m_listed <= listed;
    end
  end

`ifndef SYNTHESIS
  // A read never goes past the captured scan limit
  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (k < limit))
    else $error("scan read beyond limit");

  // The counter stays within the limit while scanning
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (k <= limit))
    else $error("scan counter past limit");

  // No read is in flight while new requests are taken
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    s_ready |-> !pend)
    else $error("read pending in idle");

  // A held answer enters the output register once it is free
  a_hold_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) && out_free |=> m_valid && (m_listed == $past(listed)))
    else $error("held answer not loaded");
`endif

endmodule
